### hw/rtl/tlc_pkg.sv
// Shared constants, types and helpers for the three-level exclusive FIFO cache.
package tlc_pkg;

    localparam int TAG_W   = 32;
    localparam int LAT_W   = 10;
    localparam int L1_DEPTH = 32;
    localparam int L2_DEPTH = 128;
    localparam int L3_DEPTH = 512;
    // RAM address widths per level
    localparam int L1_AW   = $clog2(L1_DEPTH);
    localparam int L2_AW   = $clog2(L2_DEPTH);
    localparam int L3_AW   = $clog2(L3_DEPTH);
    // count and head width, wide enough to hold the largest depth itself
    localparam int CNT_W   = $clog2(L3_DEPTH + 1);
    localparam int NLEV    = 3;
    localparam int LEV_W   = $clog2(NLEV);
    localparam int CFG_IDX_W = 8;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [LAT_W-1:0] t_lat;

    // result codes for the level that answered
    typedef enum logic [1:0] {
        HIT_L1  = 2'd0,
        HIT_L2  = 2'd1,
        HIT_L3  = 2'd2,
        HIT_RAM = 2'd3
    } t_hit;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_L1_LAT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_LAT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_LAT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_LAT = 8'd3;

    // capacity of one level
    function automatic t_cnt level_depth(input logic [LEV_W-1:0] lvl);
        t_cnt d;
        case (lvl)
            2'd0:    d = CNT_W'(L1_DEPTH);
            2'd1:    d = CNT_W'(L2_DEPTH);
            default: d = CNT_W'(L3_DEPTH);
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/tlc_ram.sv
// Generic single-port RAM with registered read.
module tlc_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/tlc_addr.sv
// Ring address unit: head plus logical offset, wrapped at the level depth.
module tlc_addr (
    input  tlc_pkg::t_cnt i_head,
    input  tlc_pkg::t_cnt i_off,
    input  tlc_pkg::t_cnt i_depth,
    output tlc_pkg::t_cnt o_phys
);
    logic [tlc_pkg::CNT_W:0] sum;
    logic [tlc_pkg::CNT_W:0] dep;
    logic [tlc_pkg::CNT_W:0] wrapped;

    assign sum     = {1'b0, i_head} + {1'b0, i_off};
    assign dep     = {1'b0, i_depth};
    assign wrapped = (sum >= dep) ? (sum - dep) : sum;
    assign o_phys  = wrapped[tlc_pkg::CNT_W-1:0];
endmodule

### hw/rtl/three_level_exclusive_fifo_cache.sv
// Top level: three exclusive FIFO cache levels searched and updated by one sequencer.
//
// Usage: one block tag enters on the input channel (i_in_valid / o_in_stall);
// one result (hit level, latency, RAM eviction) leaves on the output channel
// (o_out_valid / i_out_stall). Latency registers are written through the
// plain write port (i_cfg_we, i_cfg_index, i_cfg_data); the user must write
// them only while the block idles, as the block itself does not enforce it.
// Each level is a ring buffer in its own RAM with a head pointer and a count.
// A single tag comparator walks the levels entry by entry (read, then
// compare), a hit in L2 or L3 is closed up by copying the younger entries
// down one slot (read, then write each), and the insert into L1 cascades:
// a full level passes its oldest entry on, and L3 passes it out to RAM.
// One item is in work at a time; o_in_stall is high meanwhile.
// The result is held in an output register; a stalled receiver holds it and
// the next item may already be taken and searched.
// Reset empties all levels (counts and heads to zero) and loads the default
// latencies 4, 12, 40 and 200.
module three_level_exclusive_fifo_cache (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tlc_pkg::TAG_W-1:0]        i_block_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_hit_level,
    output logic [tlc_pkg::LAT_W-1:0]        o_latency,
    output logic                             o_ram_evict_valid,
    output logic [tlc_pkg::TAG_W-1:0]        o_ram_evict_tag,
    input  logic                             i_cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tlc_pkg::LAT_W-1:0]        i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_SRD, S_SCMP, S_RMRD, S_RMWR, S_PRD, S_PWR, S_FIN
    } t_state;

    t_state                          r_state;
    logic [tlc_pkg::LEV_W-1:0]       r_lvl;
    tlc_pkg::t_cnt                   r_idx;
    tlc_pkg::t_cnt                   r_cnt  [tlc_pkg::NLEV];
    tlc_pkg::t_cnt                   r_head [tlc_pkg::NLEV];
    tlc_pkg::t_tag                   r_tag;
    tlc_pkg::t_tag                   r_carry;
    tlc_pkg::t_hit                   r_hit;
    logic                            r_evict;
    tlc_pkg::t_tag                   r_evict_tag;
    tlc_pkg::t_lat                   r_lat [4];
    logic                            r_out_valid;
    logic [1:0]                      r_o_hit;
    tlc_pkg::t_lat                   r_o_lat;
    logic                            r_o_ev;
    tlc_pkg::t_tag                   r_o_ev_tag;

    tlc_pkg::t_cnt cur_cnt;
    tlc_pkg::t_cnt cur_head;
    tlc_pkg::t_cnt cur_depth;
    tlc_pkg::t_cnt off;
    tlc_pkg::t_cnt phys;
    tlc_pkg::t_cnt idx_inc;
    tlc_pkg::t_cnt head_next;
    logic          we;
    tlc_pkg::t_tag wdata;
    tlc_pkg::t_tag rdata;
    tlc_pkg::t_tag rd1, rd2, rd3;
    logic          out_free;

    assign cur_cnt   = r_cnt[r_lvl];
    assign cur_head  = r_head[r_lvl];
    assign cur_depth = tlc_pkg::level_depth(r_lvl);
    assign idx_inc   = r_idx + tlc_pkg::CNT_W'(1);
    assign out_free  = !r_out_valid || !i_out_stall;

    // logical offset into the current level, per sequencer step
    always_comb begin
        off   = r_idx;
        we    = 1'b0;
        wdata = r_carry;
        case (r_state)
            S_SRD:  off = r_idx;
            S_RMRD: off = idx_inc;
            S_RMWR: begin
                off   = r_idx;
                we    = 1'b1;
                wdata = rdata;
            end
            S_PRD: begin
                if (cur_cnt < cur_depth) begin
                    off = cur_cnt;
                    we  = 1'b1;
                end else begin
                    off = '0;
                end
            end
            S_PWR: begin
                off = '0;
                we  = 1'b1;
            end
            default: off = r_idx;
        endcase
    end

    tlc_addr u_addr (
        .i_head  (cur_head),
        .i_off   (off),
        .i_depth (cur_depth),
        .o_phys  (phys)
    );

    // next head after the oldest entry leaves a full level
    tlc_addr u_head (
        .i_head  (cur_head),
        .i_off   (tlc_pkg::CNT_W'(1)),
        .i_depth (cur_depth),
        .o_phys  (head_next)
    );

    tlc_ram #(.W(tlc_pkg::TAG_W), .D(tlc_pkg::L1_DEPTH)) u_l1 (
        .i_clk (i_clk), .i_we (we && r_lvl == 2'd0), .i_addr (phys[tlc_pkg::L1_AW-1:0]),
        .i_wdata (wdata), .o_rdata (rd1)
    );
    tlc_ram #(.W(tlc_pkg::TAG_W), .D(tlc_pkg::L2_DEPTH)) u_l2 (
        .i_clk (i_clk), .i_we (we && r_lvl == 2'd1), .i_addr (phys[tlc_pkg::L2_AW-1:0]),
        .i_wdata (wdata), .o_rdata (rd2)
    );
    tlc_ram #(.W(tlc_pkg::TAG_W), .D(tlc_pkg::L3_DEPTH)) u_l3 (
        .i_clk (i_clk), .i_we (we && r_lvl == 2'd2), .i_addr (phys[tlc_pkg::L3_AW-1:0]),
        .i_wdata (wdata), .o_rdata (rd3)
    );

    always_comb begin
        case (r_lvl)
            2'd0:    rdata = rd1;
            2'd1:    rdata = rd2;
            default: rdata = rd3;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer, level bookkeeping, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_evict     <= 1'b0;
            for (int k = 0; k < tlc_pkg::NLEV; k++) begin
                r_cnt[k]  <= '0;
                r_head[k] <= '0;
            end
            r_lat[0] <= tlc_pkg::LAT_W'(4);
            r_lat[1] <= tlc_pkg::LAT_W'(12);
            r_lat[2] <= tlc_pkg::LAT_W'(40);
            r_lat[3] <= tlc_pkg::LAT_W'(200);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlc_pkg::CFG_L1_LAT:  r_lat[0] <= i_cfg_data;
                    tlc_pkg::CFG_L2_LAT:  r_lat[1] <= i_cfg_data;
                    tlc_pkg::CFG_L3_LAT:  r_lat[2] <= i_cfg_data;
                    tlc_pkg::CFG_RAM_LAT: r_lat[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tag   <= i_block_tag;
                        r_lvl   <= '0;
                        r_idx   <= '0;
                        r_evict <= 1'b0;
                        r_state <= S_SRD;
                    end
                end
                // read entry, or step past an exhausted level
                S_SRD: begin
                    if (r_idx >= cur_cnt) begin
                        if (r_lvl == 2'd2) begin
                            r_hit   <= tlc_pkg::HIT_RAM;
                            r_lvl   <= '0;
                            r_carry <= r_tag;
                            r_state <= S_PRD;
                        end else begin
                            r_lvl <= r_lvl + 2'd1;
                            r_idx <= '0;
                        end
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                // shared tag comparator
                S_SCMP: begin
                    if (rdata == r_tag) begin
                        r_hit <= tlc_pkg::t_hit'(r_lvl);
                        if (r_lvl == 2'd0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RMRD;
                        end
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= S_SRD;
                    end
                end
                // close the gap left by the hit entry
                S_RMRD: begin
                    if (idx_inc >= cur_cnt) begin
                        r_cnt[r_lvl] <= cur_cnt - tlc_pkg::CNT_W'(1);
                        r_lvl        <= '0;
                        r_carry      <= r_tag;
                        r_state      <= S_PRD;
                    end else begin
                        r_state <= S_RMWR;
                    end
                end
                S_RMWR: begin
                    r_idx   <= idx_inc;
                    r_state <= S_RMRD;
                end
                // insert as newest; a full level reads its oldest first
                S_PRD: begin
                    if (cur_cnt < cur_depth) begin
                        r_cnt[r_lvl] <= cur_cnt + tlc_pkg::CNT_W'(1);
                        r_state      <= S_FIN;
                    end else begin
                        r_state <= S_PWR;
                    end
                end
                S_PWR: begin
                    r_head[r_lvl] <= head_next;
                    r_carry       <= rdata;
                    if (r_lvl == 2'd2) begin
                        r_evict     <= 1'b1;
                        r_evict_tag <= rdata;
                        r_state     <= S_FIN;
                    end else begin
                        r_lvl   <= r_lvl + 2'd1;
                        r_state <= S_PRD;
                    end
                end
                // hand the result to the output register
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_hit     <= r_hit;
                        r_o_lat     <= r_lat[r_hit];
                        r_o_ev      <= r_evict;
                        r_o_ev_tag  <= r_evict ? r_evict_tag : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit_level       = r_o_hit;
    assign o_latency         = r_o_lat;
    assign o_ram_evict_valid = r_o_ev;
    assign o_ram_evict_tag   = r_o_ev_tag;
endmodule
